/* sv/prfm_pkg.sv */
package prfm_pkg;

  localparam int NumSlots = 7;
  localparam int NumRails = 3;
  localparam int NumFuses = 4;

  localparam logic [7:0] P0InMask  = 8'h13;
  localparam logic [7:0] P1InMask  = 8'hAA;
  localparam logic [7:0] P0OutMask = 8'hEC;
  localparam logic [7:0] P1OutMask = 8'h55;

  typedef enum logic [1:0] {
    ACT_SAMPLE  = 2'd0,
    ACT_SET_BIT = 2'd1,
    ACT_SET_PORT = 2'd2,
    ACT_UNUSED  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    EV_NONE        = 3'd0,
    EV_PG_LOST     = 3'd1,
    EV_PG_RESTORED = 3'd2,
    EV_FUSE_TRIP   = 3'd3,
    EV_FUSE_CLEAR  = 3'd4
  } event_kind_t;

  typedef enum logic {
    CFG_DEVICE_PRESENT = 1'b0,
    CFG_AUTO_DISABLE   = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPLY,
    ST_SCAN,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [1:0]  port_select;
    logic [2:0]  bit_index;
    logic [7:0]  data_value;
    logic [7:0]  port0_sample;
    logic [7:0]  port1_sample;
    logic [31:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [1:0]  event_channel;
    logic [31:0] event_time;
    logic [7:0]  output_image0;
    logic [7:0]  output_image1;
    logic [2:0]  power_good_bits;
    logic [3:0]  fuse_fault_bits;
    logic        any_fault;
    logic        ok;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic load_item;
    logic apply;
    logic load_result;
  } dp_cmd_t;

  typedef struct packed {
    logic result_last;
  } dp_status_t;

endpackage

/* sv/prfm_ctrl.sv */
module prfm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output prfm_pkg::dp_cmd_t     cmd,
  input  prfm_pkg::dp_status_t  status
);

  prfm_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= prfm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      prfm_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = prfm_pkg::ST_APPLY;
      end
      prfm_pkg::ST_APPLY: begin
        state_nxt = prfm_pkg::ST_SCAN;
      end
      prfm_pkg::ST_SCAN: begin
        state_nxt = prfm_pkg::ST_SEND;
      end
      prfm_pkg::ST_SEND: begin
        if (out_ready) begin
          state_nxt = status.result_last ? prfm_pkg::ST_IDLE : prfm_pkg::ST_SCAN;
        end
      end
      default: state_nxt = prfm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    out_valid       = 1'b0;
    cmd.load_item   = 1'b0;
    cmd.apply       = 1'b0;
    cmd.load_result = 1'b0;
    unique case (state_r)
      prfm_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      prfm_pkg::ST_APPLY: begin
        cmd.apply = 1'b1;
      end
      prfm_pkg::ST_SCAN: begin
        cmd.load_result = 1'b1;
      end
      prfm_pkg::ST_SEND: begin
        out_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

/* sv/prfm_dp.sv */
module prfm_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  prfm_pkg::in_item_t    in_data,
  output prfm_pkg::out_item_t   out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_index,
  input  logic                  cfg_data,
  input  prfm_pkg::dp_cmd_t     cmd,
  output prfm_pkg::dp_status_t  status
);

  logic                 present_r;
  logic                 auto_dis_r;
  logic [7:0]           img0_r, img0_nxt;
  logic [7:0]           img1_r, img1_nxt;
  logic [7:0]           oreg0_r, oreg0_nxt;
  logic [7:0]           oreg1_r, oreg1_nxt;
  logic                 armed_r, armed_nxt;
  logic                 ok_r, ok_nxt;
  logic [prfm_pkg::NumSlots-1:0] chg_r, chg_nxt;
  prfm_pkg::in_item_t   item_r;
  prfm_pkg::out_item_t  out_r, out_nxt;

  logic                 do_sample, do_set_bit, do_set_port;
  logic [7:0]           pgc, flc;
  logic [7:0]           bit_mask;
  logic [7:0]           sel_reg, sel_new, port_mask;
  logic [prfm_pkg::NumSlots-1:0] pick, chg_left;
  logic [2:0]           slot;
  logic [1:0]           fuse;
  logic [2:0]           pg_bits;
  logic [3:0]           ff_bits;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r  <= 1'b0;
      auto_dis_r <= 1'b1;
    end else if (cfg_valid) begin
      unique case (prfm_pkg::cfg_index_t'(cfg_index))
        prfm_pkg::CFG_DEVICE_PRESENT: present_r  <= cfg_data;
        prfm_pkg::CFG_AUTO_DISABLE:   auto_dis_r <= cfg_data;
        default:                      present_r  <= present_r;
      endcase
    end
  end

  assign pg_bits = {img0_r[4], img0_r[1], img0_r[0]};
  assign ff_bits = ~{img1_r[7], img1_r[5], img1_r[3], img1_r[1]};

  // action decode
  always_comb begin
    do_sample   = present_r && (item_r.action == prfm_pkg::ACT_SAMPLE);
    do_set_bit  = present_r && (item_r.action == prfm_pkg::ACT_SET_BIT)
                  && !item_r.port_select[1];
    do_set_port = present_r && (item_r.action == prfm_pkg::ACT_SET_PORT)
                  && !item_r.port_select[1];
    pgc      = (img0_r ^ item_r.port0_sample) & prfm_pkg::P0InMask;
    flc      = (img1_r ^ item_r.port1_sample) & prfm_pkg::P1InMask;
    bit_mask = 8'b1 << item_r.bit_index;
    sel_reg  = item_r.port_select[0] ? oreg1_r : oreg0_r;
    port_mask = item_r.port_select[0] ? prfm_pkg::P1OutMask : prfm_pkg::P0OutMask;
    if (do_set_bit) begin
      sel_new = item_r.data_value[0] ? (sel_reg | bit_mask) : (sel_reg & ~bit_mask);
    end else begin
      sel_new = (sel_reg & ~port_mask) | (item_r.data_value & port_mask);
    end
  end

  // lowest pending pin change
  always_comb begin
    pick     = chg_r & (~chg_r + 7'd1);
    chg_left = chg_r & ~pick;
    slot     = '0;
    for (int j = 0; j < prfm_pkg::NumSlots; j++) begin
      if (pick[j]) slot = 3'(j);
    end
    fuse = 2'(slot - 3'(prfm_pkg::NumRails));
  end

  always_comb begin
    img0_nxt  = img0_r;
    img1_nxt  = img1_r;
    oreg0_nxt = oreg0_r;
    oreg1_nxt = oreg1_r;
    armed_nxt = armed_r;
    ok_nxt    = ok_r;
    chg_nxt   = chg_r;
    out_nxt   = out_r;
    if (cmd.apply) begin
      ok_nxt  = do_sample || do_set_bit || do_set_port;
      chg_nxt = '0;
      if (do_sample) begin
        img0_nxt  = item_r.port0_sample;
        img1_nxt  = item_r.port1_sample;
        armed_nxt = 1'b1;
        if (armed_r) begin
          chg_nxt = {flc[7], flc[5], flc[3], flc[1], pgc[4], pgc[1], pgc[0]};
        end
      end
      if (do_set_bit || do_set_port) begin
        if (item_r.port_select[0]) oreg1_nxt = sel_new;
        else                       oreg0_nxt = sel_new;
      end
    end
    if (cmd.load_result) begin
      out_nxt.event_kind    = prfm_pkg::EV_NONE;
      out_nxt.event_channel = '0;
      out_nxt.event_time    = '0;
      out_nxt.ok            = ok_r;
      out_nxt.last          = 1'b1;
      if (chg_r != '0) begin
        out_nxt.event_time = item_r.time_ms;
        out_nxt.last       = (chg_left == '0);
        chg_nxt            = chg_left;
        if (slot < 3'(prfm_pkg::NumRails)) begin
          out_nxt.event_channel = slot[1:0];
          out_nxt.event_kind    = pg_bits[slot[1:0]] ? prfm_pkg::EV_PG_RESTORED
                                                     : prfm_pkg::EV_PG_LOST;
        end else begin
          out_nxt.event_channel = fuse;
          if (ff_bits[fuse]) begin
            out_nxt.event_kind = prfm_pkg::EV_FUSE_TRIP;
            if (auto_dis_r) oreg1_nxt[{fuse, 1'b0}] = 1'b0;
          end else begin
            out_nxt.event_kind = prfm_pkg::EV_FUSE_CLEAR;
          end
        end
      end
      out_nxt.output_image0   = oreg0_nxt;
      out_nxt.output_image1   = oreg1_nxt;
      out_nxt.power_good_bits = pg_bits;
      out_nxt.fuse_fault_bits = ff_bits;
      out_nxt.any_fault       = present_r && ((ff_bits != '0) || !pg_bits[0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img0_r  <= '0;
      img1_r  <= '0;
      oreg0_r <= '0;
      oreg1_r <= '0;
      armed_r <= 1'b0;
    end else begin
      img0_r  <= img0_nxt;
      img1_r  <= img1_nxt;
      oreg0_r <= oreg0_nxt;
      oreg1_r <= oreg1_nxt;
      armed_r <= armed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) item_r <= in_data;
    ok_r  <= ok_nxt;
    chg_r <= chg_nxt;
    out_r <= out_nxt;
  end

  assign out_data           = out_r;
  assign status.result_last = out_r.last;

endmodule

/* sv/power_rail_fault_monitor_top.sv */
// channel  | ports                          | payload
// input    | in_valid / in_ready            | in_data  (prfm_pkg::in_item_t)
// result   | out_valid / out_ready          | out_data (prfm_pkg::out_item_t)
// config   | cfg_valid / cfg_ready          | cfg_index, cfg_data
//
// one item at a time: accept, apply, then per result a scan state and
// a send state that waits for out_ready
// the fsm walks pending pin changes lowest first, one per result
// reset is synchronous, active low; images, outputs and arming clear
// a stalled result holds in the output register until out_ready
// config writes are always taken
module power_rail_fault_monitor_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  prfm_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output prfm_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic                 cfg_data
);

  prfm_pkg::dp_cmd_t    cmd;
  prfm_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  prfm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  prfm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

/* sv/prfm_checker.sv */
module prfm_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input prfm_pkg::out_item_t  out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("second item or early result after accept");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("item taken while a result is pending");

  a_refused: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.ok |-> out_data.last
      && out_data.event_kind == prfm_pkg::EV_NONE && !out_data.any_fault
      || out_valid && !out_data.ok && out_data.last
      && out_data.event_kind == prfm_pkg::EV_NONE)
    else $error("refused item gave more than one plain result");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.event_kind == prfm_pkg::EV_NONE |->
      out_data.event_time == '0 && out_data.event_channel == '0 && out_data.last)
    else $error("plain result carries event fields");

endmodule

bind power_rail_fault_monitor_top prfm_checker u_prfm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam int PhaseItems = 62;
  localparam int HoldCycles = 300;
  localparam int DrainWait  = 20;
  localparam int CycleLimit = 1000000;

  class rail_scoreboard;
    logic                 present;
    logic                 auto_off;
    logic                 armed;
    logic [7:0]           in_img0;
    logic [7:0]           in_img1;
    logic [7:0]           out_img0;
    logic [7:0]           out_img1;
    prfm_pkg::out_item_t  due_results[$];
    int                   errors;
    int                   checked;
    int                   events;

    function new();
      present  = 1'b0;
      auto_off = 1'b1;
      armed    = 1'b0;
      in_img0  = '0;
      in_img1  = '0;
      out_img0 = '0;
      out_img1 = '0;
      errors   = 0;
      checked  = 0;
      events   = 0;
    endfunction

    function void note_config(logic idx, logic val);
      if (idx == prfm_pkg::CFG_DEVICE_PRESENT) begin
        present = val;
      end else begin
        auto_off = val;
      end
    endfunction

    function logic [7:0] rail_pin(int rail);
      return (rail == 2) ? 8'h10 : (8'h01 << rail);
    endfunction

    // status fields come from the stored pin images and output images
    function prfm_pkg::out_item_t status(prfm_pkg::event_kind_t kind, logic [1:0] chan,
                                         logic [31:0] stamp, logic acc);
      prfm_pkg::out_item_t r;
      logic [2:0]          pg;
      logic [3:0]          ff;
      for (int i = 0; i < prfm_pkg::NumRails; i++) pg[i] = |(in_img0 & rail_pin(i));
      for (int i = 0; i < prfm_pkg::NumFuses; i++) ff[i] = !in_img1[2*i+1];
      r.event_kind      = kind;
      r.event_channel   = chan;
      r.event_time      = stamp;
      r.output_image0   = out_img0;
      r.output_image1   = out_img1;
      r.power_good_bits = pg;
      r.fuse_fault_bits = ff;
      r.any_fault       = present && (ff != 4'd0 || !pg[0]);
      r.ok              = acc;
      r.last            = 1'b0;
      return r;
    endfunction

    function void apply_item(prfm_pkg::in_item_t it);
      prfm_pkg::out_item_t res[prfm_pkg::NumSlots];
      int                  n;
      logic                acc;
      logic                trip;
      logic [7:0]          pg_chg;
      logic [7:0]          fuse_chg;
      logic [7:0]          pin;
      n   = 0;
      acc = 1'b0;
      if (present && it.action == prfm_pkg::ACT_SAMPLE) begin
        pg_chg   = (in_img0 ^ it.port0_sample) & prfm_pkg::P0InMask;
        fuse_chg = (in_img1 ^ it.port1_sample) & prfm_pkg::P1InMask;
        in_img0  = it.port0_sample;
        in_img1  = it.port1_sample;
        acc      = 1'b1;
        if (armed) begin
          for (int i = 0; i < prfm_pkg::NumRails; i++) begin
            if (|(pg_chg & rail_pin(i))) begin
              res[n] = status(|(it.port0_sample & rail_pin(i)) ? prfm_pkg::EV_PG_RESTORED
                                                                : prfm_pkg::EV_PG_LOST,
                              2'(i), it.time_ms, 1'b1);
              n++;
            end
          end
          for (int i = 0; i < prfm_pkg::NumFuses; i++) begin
            pin = 8'h02 << (2 * i);
            if (|(fuse_chg & pin)) begin
              trip = !(|(it.port1_sample & pin));
              // with auto-disable on, a tripped fuse loses its enable before the event goes out
              if (trip && auto_off) out_img1[2*i] = 1'b0;
              res[n] = status(trip ? prfm_pkg::EV_FUSE_TRIP : prfm_pkg::EV_FUSE_CLEAR,
                              2'(i), it.time_ms, 1'b1);
              n++;
            end
          end
        end
        armed = 1'b1;
      end else if (present && it.action == prfm_pkg::ACT_SET_BIT
                   && it.port_select <= 2'd1) begin
        if (it.port_select == 2'd0) begin
          out_img0[it.bit_index] = it.data_value[0];
        end else begin
          out_img1[it.bit_index] = it.data_value[0];
        end
        acc = 1'b1;
      end else if (present && it.action == prfm_pkg::ACT_SET_PORT
                   && it.port_select <= 2'd1) begin
        if (it.port_select == 2'd0) begin
          out_img0 = (out_img0 & ~prfm_pkg::P0OutMask) | (it.data_value & prfm_pkg::P0OutMask);
        end else begin
          out_img1 = (out_img1 & ~prfm_pkg::P1OutMask) | (it.data_value & prfm_pkg::P1OutMask);
        end
        acc = 1'b1;
      end
      if (n == 0) begin
        res[0] = status(prfm_pkg::EV_NONE, 2'd0, 32'd0, acc);
        n = 1;
      end
      res[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) due_results.push_back(res[i]);
    endfunction

    task report(string msg);
      if (errors < 50) $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task cmp(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
        report($sformatf("result %0d %s got %0h want %0h", checked, name, got, want));
      end
    endtask

    task check_result(prfm_pkg::out_item_t got);
      prfm_pkg::out_item_t want;
      if (due_results.size() == 0) begin
        report($sformatf("result %h with nothing expected", got));
        return;
      end
      want = due_results.pop_front();
      checked++;
      if (want.event_kind != prfm_pkg::EV_NONE) events++;
      cmp("event_kind", 32'(got.event_kind), 32'(want.event_kind));
      cmp("event_channel", 32'(got.event_channel), 32'(want.event_channel));
      cmp("event_time", got.event_time, want.event_time);
      cmp("output_image0", 32'(got.output_image0), 32'(want.output_image0));
      cmp("output_image1", 32'(got.output_image1), 32'(want.output_image1));
      cmp("power_good_bits", 32'(got.power_good_bits), 32'(want.power_good_bits));
      cmp("fuse_fault_bits", 32'(got.fuse_fault_bits), 32'(want.fuse_fault_bits));
      cmp("any_fault", 32'(got.any_fault), 32'(want.any_fault));
      cmp("ok", 32'(got.ok), 32'(want.ok));
      cmp("last", 32'(got.last), 32'(want.last));
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  prfm_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  prfm_pkg::out_item_t out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic                cfg_index;
  logic                cfg_data;

  rail_scoreboard board = new();
  int         cycles;
  int         accepted;
  int         cfg_writes;
  bit         no_gaps;
  bit         no_stalls;
  bit         hold_req;
  logic [7:0] pins0;
  logic [7:0] pins1;

  power_rail_fault_monitor_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = prfm_pkg::CFG_DEVICE_PRESENT;
    cfg_data   = 1'b0;
    cycles     = 0;
    accepted   = 0;
    cfg_writes = 0;
    no_gaps    = 1'b0;
    no_stalls  = 1'b0;
    hold_req   = 1'b0;
    pins0      = 8'h13;
    pins1      = 8'hAA;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end else if (rst_n) begin
      if (in_valid && in_ready) begin
        board.apply_item(in_data);
        accepted++;
      end
      if (out_valid && out_ready) board.check_result(out_data);
      if (cfg_valid && cfg_ready) begin
        board.note_config(cfg_index, cfg_data);
        cfg_writes++;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin : result_sink
    int n;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        n = no_stalls ? 0 : pick_gap();
        if (n > 0) begin
          out_ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  task automatic send(prfm_pkg::in_item_t it);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.due_results.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic set_config(logic present, logic auto_off);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= prfm_pkg::CFG_DEVICE_PRESENT;
    cfg_data  <= present;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= prfm_pkg::CFG_AUTO_DISABLE;
    cfg_data  <= auto_off;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic prfm_pkg::in_item_t mk(prfm_pkg::action_t act, logic [1:0] port,
                                            logic [2:0] bidx, logic [7:0] val,
                                            logic [7:0] s0, logic [7:0] s1,
                                            logic [31:0] stamp);
    prfm_pkg::in_item_t it;
    it.action       = act;
    it.port_select  = port;
    it.bit_index    = bidx;
    it.data_value   = val;
    it.port0_sample = s0;
    it.port1_sample = s1;
    it.time_ms      = stamp;
    return it;
  endfunction

  // samples mostly walk the pins a few at a time so edges stay frequent
  function automatic prfm_pkg::in_item_t rand_item();
    prfm_pkg::in_item_t it;
    int                 r;
    it = mk(prfm_pkg::ACT_SAMPLE, 2'($urandom_range(0, 1)), 3'($urandom), 8'($urandom),
            8'($urandom), 8'($urandom), $urandom);
    r = $urandom_range(0, 99);
    if (r < 60) begin
      if ($urandom_range(0, 9) == 0) begin
        pins0 = 8'($urandom);
        pins1 = 8'($urandom);
      end else begin
        pins0 ^= (8'($urandom) & 8'($urandom) & prfm_pkg::P0InMask)
                 | (8'($urandom) & 8'($urandom));
        pins1 ^= (8'($urandom) & 8'($urandom) & prfm_pkg::P1InMask)
                 | (8'($urandom) & 8'($urandom));
      end
      it.port0_sample = pins0;
      it.port1_sample = pins1;
    end else if (r < 75) begin
      it.action = prfm_pkg::ACT_SET_BIT;
    end else if (r < 90) begin
      it.action = prfm_pkg::ACT_SET_PORT;
    end else begin
      it.action      = 2'($urandom_range(0, 3));
      it.port_select = 2'($urandom_range(2, 3));
      if ($urandom_range(0, 1) == 1) it.action = prfm_pkg::ACT_UNUSED;
    end
    return it;
  endfunction

  initial begin : stimulus
    int n;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // expander absent after reset
    send(mk(prfm_pkg::ACT_SAMPLE, 2'd0, 3'd0, 8'h00, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
    send(mk(prfm_pkg::ACT_SET_PORT, 2'd1, 3'd7, 8'hFF, 8'h00, 8'h00, 32'd0));

    set_config(1'b1, 1'b1);
    send(mk(prfm_pkg::ACT_SAMPLE, 2'd0, 3'd0, 8'h00, 8'h13, 8'hAA, 32'd0));
    send(mk(prfm_pkg::ACT_SET_PORT, 2'd1, 3'd0, 8'hFF, 8'h00, 8'h00, 32'd0));
    send(mk(prfm_pkg::ACT_SET_PORT, 2'd0, 3'd0, 8'hFF, 8'h00, 8'h00, 32'd0));
    // every monitored pin drops at once, then comes back
    send(mk(prfm_pkg::ACT_SAMPLE, 2'd3, 3'd7, 8'hFF, 8'h00, 8'h00, 32'hFFFF_FFFF));
    send(mk(prfm_pkg::ACT_SAMPLE, 2'd0, 3'd0, 8'h00, 8'h13, 8'hAA, 32'h0000_0001));
    send(mk(prfm_pkg::ACT_SAMPLE, 2'd0, 3'd0, 8'h00, 8'hFF, 8'hFF, 32'h8000_0000));
    send(mk(prfm_pkg::ACT_SAMPLE, 2'd0, 3'd0, 8'h00, 8'hFF, 8'hFF, 32'h7FFF_FFFF));
    send(mk(prfm_pkg::ACT_SET_BIT, 2'd0, 3'd7, 8'h01, 8'h00, 8'h00, 32'd0));
    send(mk(prfm_pkg::ACT_SET_BIT, 2'd1, 3'd0, 8'hFE, 8'h00, 8'h00, 32'd0));
    send(mk(prfm_pkg::ACT_SET_BIT, 2'd0, 3'd1, 8'hFF, 8'h00, 8'h00, 32'd0));
    send(mk(prfm_pkg::ACT_SET_PORT, 2'd0, 3'd0, 8'h00, 8'h00, 8'h00, 32'd0));
    send(mk(prfm_pkg::ACT_SET_PORT, 2'd2, 3'd0, 8'hFF, 8'h00, 8'h00, 32'd0));
    send(mk(prfm_pkg::ACT_SET_BIT, 2'd3, 3'd5, 8'h01, 8'h00, 8'h00, 32'd0));
    send(mk(prfm_pkg::ACT_UNUSED, 2'd0, 3'd0, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF));

    // faults without auto-disable keep the enables
    set_config(1'b1, 1'b0);
    send(mk(prfm_pkg::ACT_SET_PORT, 2'd1, 3'd0, 8'hFF, 8'h00, 8'h00, 32'd0));
    send(mk(prfm_pkg::ACT_SAMPLE, 2'd0, 3'd0, 8'h00, 8'hEC, 8'h55, 32'h1234_5678));

    set_config(1'b0, 1'b1);
    send(mk(prfm_pkg::ACT_SAMPLE, 2'd0, 3'd0, 8'h00, 8'h13, 8'hAA, 32'h0000_00FF));
    set_config(1'b1, 1'b1);
    send(mk(prfm_pkg::ACT_SAMPLE, 2'd0, 3'd0, 8'h00, 8'h13, 8'hAA, 32'h0000_0100));

    for (int ph = 0; ph < 6; ph++) begin
      set_config(ph != 2, (ph % 2) == 0);
      n         = (ph == 2) ? 20 : PhaseItems;
      no_stalls = (ph == 5);
      no_gaps   = (ph == 3 || ph == 5);
      if (ph == 3) hold_req = 1'b1;
      for (int k = 0; k < n; k++) begin
        if (ph == 3 && k == 30) no_gaps = 1'b0;
        send(rand_item());
      end
      no_gaps = 1'b0;
    end
    no_stalls = 1'b0;

    drain();
    $display("covered %0d items, %0d results checked, %0d of them pin events",
             accepted, board.checked, board.events);
    $display("%0d register writes, one %0d-cycle receiver hold under back-to-back input",
             cfg_writes, HoldCycles);
    if (board.errors == 0 && board.due_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
